[rtl/bfa_pkg.sv]
// ---------------------------------------------------------------------------
// bfa_pkg
// shared sizes, operation and status codes and item types of the frame allocator
// ---------------------------------------------------------------------------
package bfa_pkg;

    localparam int NUM_FRAMES   = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int FRAME_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W        = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W        = 7;
    localparam int PAGE_CNT_W   = 6;
    localparam int FRAME_NUM_W  = 5;
    localparam int PAGE_IDX_W   = 5;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [PAGE_CNT_W-1:0]  page_count;
        logic [FRAME_NUM_W-1:0] frame_to_free;
    } t_req;

    typedef struct packed {
        logic                   status;
        logic                   frame_valid;
        logic [PAGE_IDX_W-1:0]  page_index;
        logic [FRAME_NUM_W-1:0] frame_number;
        logic                   last;
    } t_res;

endpackage

[rtl/bfa_if.sv]
// ---------------------------------------------------------------------------
// bfa_req_if / bfa_res_if
// valid/ready channels carrying request and result items
// ---------------------------------------------------------------------------
interface bfa_req_if;
    logic          valid;
    logic          ready;
    bfa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfa_res_if;
    logic          valid;
    logic          ready;
    bfa_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/bitmap_frame_allocator.sv]
// ---------------------------------------------------------------------------
// bitmap_frame_allocator
// first-fit page frame allocator over a one-bit-per-frame occupancy memory
// ---------------------------------------------------------------------------
// After reset the block sweeps the occupancy memory clear, one frame a cycle,
// and takes no item meanwhile. An allocate item then walks the frames upward
// from frame 0 through the memory's read and write ports: each frame passes a
// read state and a check state, one result per frame taken, and a free frame
// waits in the check state while the result register is full. A failing or
// zero-page request is decided at once, a failing one from a running free
// count and the result limit, and gives its single result from the put state
// once the result register is free. A free item reads the frame's bit, then
// clears it if set, and gives no result. One item is worked on at a time; the
// result register lets the next item be accepted while the last result still waits.
module bitmap_frame_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfa_req_if.sink       i_req,
    bfa_res_if.source     o_res
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_FREE_CHK = 3'd4;
    localparam logic [2:0] S_PUT      = 3'd5;

    // occupancy memory
    logic                        mem [bfa_pkg::NUM_FRAMES];
    logic                        r_rd_data;
    logic                        w_re;
    logic [bfa_pkg::FRAME_W-1:0] w_rd_addr;
    logic                        w_we;
    logic                        w_wr_data;

    logic [2:0]                     r_state,    n_state;
    logic [bfa_pkg::FRAME_W-1:0]    r_addr,     n_addr;
    logic [bfa_pkg::CNT_W-1:0]      r_free_cnt, n_free_cnt;
    logic [bfa_pkg::PAGE_CNT_W-1:0] r_want,     n_want;
    logic [bfa_pkg::PAGE_IDX_W-1:0] r_page,     n_page;
    logic                           r_put_status, n_put_status;
    logic                           r_out_valid, n_out_valid;
    bfa_pkg::t_res                  r_res,      n_res;

    logic w_slot;
    logic w_accept;
    logic w_last;
    logic w_fits;
    logic w_in_range;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_addr] <= w_wr_data;
        end
        if (w_re) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    assign w_slot   = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept = i_req.valid && i_req.ready;
    assign w_last   = ((bfa_pkg::PAGE_CNT_W'(r_page) + bfa_pkg::PAGE_CNT_W'(1)) == r_want);

    assign w_fits = (i_req.data.page_count != '0)
        && (bfa_pkg::CMP_W'(i_req.data.page_count) <= bfa_pkg::CMP_W'(bfa_pkg::MAX_RESULTS))
        && (bfa_pkg::CMP_W'(i_req.data.page_count) <= bfa_pkg::CMP_W'(r_free_cnt));
    assign w_in_range = bfa_pkg::CMP_W'(i_req.data.frame_to_free)
        < bfa_pkg::CMP_W'(bfa_pkg::NUM_FRAMES);

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_free_cnt   = r_free_cnt;
        n_want       = r_want;
        n_page       = r_page;
        n_put_status = r_put_status;
        n_out_valid  = r_out_valid;
        n_res        = r_res;
        w_re         = 1'b0;
        w_rd_addr    = r_addr;
        w_we         = 1'b0;
        w_wr_data    = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_addr == bfa_pkg::FRAME_W'(bfa_pkg::NUM_FRAMES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + bfa_pkg::FRAME_W'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.data.func == bfa_pkg::FUNC_FREE) begin
                        if (w_in_range) begin
                            w_re      = 1'b1;
                            w_rd_addr = bfa_pkg::FRAME_W'(i_req.data.frame_to_free);
                            n_addr    = bfa_pkg::FRAME_W'(i_req.data.frame_to_free);
                            n_state   = S_FREE_CHK;
                        end
                    end else if (i_req.data.page_count == '0) begin
                        n_put_status = bfa_pkg::STATUS_OK;
                        n_state      = S_PUT;
                    end else if (!w_fits) begin
                        n_put_status = bfa_pkg::STATUS_FAIL;
                        n_state      = S_PUT;
                    end else begin
                        n_want  = i_req.data.page_count;
                        n_page  = '0;
                        n_addr  = '0;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                w_re    = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_rd_data) begin
                    n_addr  = r_addr + bfa_pkg::FRAME_W'(1);
                    n_state = S_SCAN_RD;
                end else if (w_slot) begin
                    w_we        = 1'b1;
                    w_wr_data   = 1'b1;
                    n_free_cnt  = r_free_cnt - bfa_pkg::CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_res.status       = bfa_pkg::STATUS_OK;
                    n_res.frame_valid  = 1'b1;
                    n_res.page_index   = r_page;
                    n_res.frame_number = bfa_pkg::FRAME_NUM_W'(r_addr);
                    n_res.last         = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_page  = r_page + bfa_pkg::PAGE_IDX_W'(1);
                        n_addr  = r_addr + bfa_pkg::FRAME_W'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_FREE_CHK: begin
                // only an occupied frame gives a frame back to the count
                if (r_rd_data) begin
                    w_we       = 1'b1;
                    n_free_cnt = r_free_cnt + bfa_pkg::CNT_W'(1);
                end
                n_state = S_IDLE;
            end
            S_PUT: begin
                if (w_slot) begin
                    n_out_valid        = 1'b1;
                    n_res.status       = r_put_status;
                    n_res.frame_valid  = 1'b0;
                    n_res.page_index   = '0;
                    n_res.frame_number = '0;
                    n_res.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_free_cnt  <= bfa_pkg::CNT_W'(bfa_pkg::NUM_FRAMES);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
        end
        r_want       <= n_want;
        r_page       <= n_page;
        r_put_status <= n_put_status;
        r_res        <= n_res;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // free count can never pass the number of frames
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= bfa_pkg::CNT_W'(bfa_pkg::NUM_FRAMES))
        else $error("free count above frame count");

    // a running scan always has enough free frames left to finish
    a_scan_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD || r_state == S_SCAN_CHK) |->
        (bfa_pkg::CMP_W'(r_want) - bfa_pkg::CMP_W'(r_page) <= bfa_pkg::CMP_W'(r_free_cnt)))
        else $error("scan outran the free frames");

    // no item taken while the memory is being cleared
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("item accepted during clearing pass");

    // a scan only marks a frame that it has just read as free
    a_mark_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK && w_we) |-> (!r_rd_data && n_out_valid))
        else $error("scan marked an occupied frame");

    // a result is only loaded into a free or draining slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> ($stable(r_res) && r_out_valid))
        else $error("pending result overwritten");

endmodule

[tb/bitmap_frame_allocator_test.sv]
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_test
// self-checking bench for the first-fit page frame allocator
// ---------------------------------------------------------------------------
// Request items go in over the request channel and every result item is
// checked against a model of the occupancy bitmap. The model lives in a small
// scoreboard class. A directed opening covers zero-page, full, failing and
// over-limit requests, plus frees of frames that are already free. A random
// run then follows with mostly small allocations, frees biased towards frames
// in use, and full release sweeps. Both channel sides idle at random.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    // occupancy model plus the queue of grants still owed by the block
    class frame_grant_board;
        bit            frame_taken [bfa_pkg::NUM_FRAMES];
        bfa_pkg::t_res pending_grants [$];
        int            errors;

        function new();
            foreach (frame_taken[f]) frame_taken[f] = 1'b0;
            errors = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        // works out the grants one accepted request item causes
        function void note_request(input bfa_pkg::t_req r);
            int            free_frames;
            int            taken;
            bfa_pkg::t_res g;
            if (r.func == bfa_pkg::FUNC_FREE) begin
                if (int'(r.frame_to_free) < bfa_pkg::NUM_FRAMES)
                    frame_taken[r.frame_to_free] = 1'b0;
                return;
            end
            g = '0;
            g.last = 1'b1;
            if (r.page_count == 0) begin
                g.status = bfa_pkg::STATUS_OK;
                pending_grants.push_back(g);
                return;
            end
            free_frames = 0;
            foreach (frame_taken[f]) if (!frame_taken[f]) free_frames++;
            // over-limit requests fail like a shortage, nothing is kept
            if (int'(r.page_count) > bfa_pkg::MAX_RESULTS
                || free_frames < int'(r.page_count)) begin
                g.status = bfa_pkg::STATUS_FAIL;
                pending_grants.push_back(g);
                return;
            end
            taken = 0;
            for (int f = 0; f < bfa_pkg::NUM_FRAMES && taken < int'(r.page_count); f++) begin
                if (!frame_taken[f]) begin
                    frame_taken[f]  = 1'b1;
                    g.status        = bfa_pkg::STATUS_OK;
                    g.frame_valid   = 1'b1;
                    g.page_index    = bfa_pkg::PAGE_IDX_W'(taken);
                    g.frame_number  = bfa_pkg::FRAME_NUM_W'(f);
                    g.last          = (taken + 1 == int'(r.page_count));
                    pending_grants.push_back(g);
                    taken++;
                end
            end
        endfunction

        task check_field(input string name, input int got, input int want);
            if (got != want)
                report($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_grant(input bfa_pkg::t_res got);
            bfa_pkg::t_res want;
            if (pending_grants.size() == 0) begin
                report("result item with nothing expected");
                return;
            end
            want = pending_grants.pop_front();
            check_field("status", int'(got.status), int'(want.status));
            check_field("frame_valid", int'(got.frame_valid), int'(want.frame_valid));
            check_field("page_index", int'(got.page_index), int'(want.page_index));
            check_field("frame_number", int'(got.frame_number), int'(want.frame_number));
            check_field("last", int'(got.last), int'(want.last));
        endtask

        // mostly a frame in use, so frees actually release something
        function int pick_taken_frame();
            int in_use [$];
            foreach (frame_taken[f]) if (frame_taken[f]) in_use.push_back(f);
            if (in_use.size() == 0 || $urandom_range(99) < 20)
                return $urandom_range(bfa_pkg::NUM_FRAMES - 1);
            return in_use[$urandom_range(in_use.size() - 1)];
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   gaps_on = 1'b1;

    bfa_req_if req_ch();
    bfa_res_if res_ch();

    frame_grant_board board = new();

    bitmap_frame_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: check what was taken, then choose the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_grant(res_ch.data);
        res_ch.ready <= !(gaps_on && $urandom_range(99) < 10);
    end

    task automatic send_request(input bfa_pkg::t_req r);
        if (gaps_on && $urandom_range(99) < 10) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(r);
    endtask

    task automatic alloc_pages(input int n);
        bfa_pkg::t_req r;
        r.func          = bfa_pkg::FUNC_ALLOC;
        r.page_count    = bfa_pkg::PAGE_CNT_W'(n);
        r.frame_to_free = bfa_pkg::FRAME_NUM_W'($urandom_range(31));
        send_request(r);
    endtask

    task automatic free_frame(input int f);
        bfa_pkg::t_req r;
        r.func          = bfa_pkg::FUNC_FREE;
        r.page_count    = bfa_pkg::PAGE_CNT_W'($urandom_range(63));
        r.frame_to_free = bfa_pkg::FRAME_NUM_W'(f);
        send_request(r);
    endtask

    task automatic wait_drained();
        while (board.pending_grants.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int roll;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        alloc_pages(0);
        alloc_pages(bfa_pkg::NUM_FRAMES);   // whole memory
        alloc_pages(1);                     // full, must fail
        alloc_pages(0);                     // zero pages while full still succeeds
        free_frame(31);
        free_frame(0);
        free_frame(0);                      // already free
        free_frame(15);
        alloc_pages(63);                    // above the result limit
        alloc_pages(bfa_pkg::MAX_RESULTS + 1);
        alloc_pages(3);                     // takes 0, 15, 31 in that order
        alloc_pages(1);
        free_frame(7);
        alloc_pages(2);                     // one short
        alloc_pages(1);
        free_frame(31);
        free_frame(30);
        alloc_pages(2);

        // random run
        for (int n = 0; n < 180; n++) begin
            gaps_on = !(n >= 90 && n < 130);
            if (n == 60 || n == 140) begin
                for (int f = 0; f < bfa_pkg::NUM_FRAMES; f++) free_frame(f);
                req_ch.valid <= 1'b0;
                wait_drained();
                @(posedge i_clk);
                alloc_pages(bfa_pkg::NUM_FRAMES);
            end
            roll = $urandom_range(99);
            if (roll < 50) begin
                free_frame(board.pick_taken_frame());
            end else if (roll < 55) begin
                alloc_pages(0);
            end else if (roll < 60) begin
                alloc_pages($urandom_range(bfa_pkg::MAX_RESULTS + 1, 63));
            end else if (roll < 67) begin
                alloc_pages($urandom_range(9, bfa_pkg::MAX_RESULTS));
            end else begin
                alloc_pages($urandom_range(1, 8));
            end
        end
        req_ch.valid <= 1'b0;

        wait_drained();
        repeat (2 * bfa_pkg::NUM_FRAMES + 8) @(posedge i_clk);
        if (board.errors == 0)
            $display("** bitmap_frame_allocator: PASSED **");
        else
            $display("** bitmap_frame_allocator: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** bitmap_frame_allocator: FAILED **");
        $finish;
    end

endmodule
